// ===== sv/planned_trajectory_tracking_step_unit_assert.svh =====
// Assertion macros for the planned trajectory tracking step unit
`ifndef PLANNED_TRAJECTORY_TRACKING_STEP_UNIT_ASSERT_SVH
`define PLANNED_TRAJECTORY_TRACKING_STEP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define PTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTT_ASSERT(lbl, prop, msg)
`define PTT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/ptt_pkg.sv =====
// Shared constants, register map and helper functions of the tracking step unit
package ptt_pkg;

  // register map
  localparam int NUM_CFG         = 7;
  localparam int CFG_W           = 17;
  localparam int ADDR_W          = 5;
  localparam logic [2:0] REG_VEL_DECAY    = 3'd0;
  localparam logic [2:0] REG_VEL_TO_POS   = 3'd1;
  localparam logic [2:0] REG_INPUT_TO_VEL = 3'd2;
  localparam logic [2:0] REG_INPUT_TO_POS = 3'd3;
  localparam logic [2:0] REG_VEL_GAIN     = 3'd4;
  localparam logic [2:0] REG_POS_GAIN     = 3'd5;
  localparam logic [2:0] REG_CMD_SCALE    = 3'd6;

  localparam logic [CFG_W-1:0] RST_VEL_DECAY    = 17'd60797;
  localparam logic [CFG_W-1:0] RST_VEL_TO_POS   = 17'd6314;
  localparam logic [CFG_W-1:0] RST_INPUT_TO_VEL = 17'd61938;
  localparam logic [CFG_W-1:0] RST_INPUT_TO_POS = 17'd3136;
  localparam logic [CFG_W-1:0] RST_VEL_GAIN     = 17'd16384;
  localparam logic [CFG_W-1:0] RST_POS_GAIN     = 17'd65536;
  localparam logic [CFG_W-1:0] RST_CMD_SCALE    = 17'd32768;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // stream widths
  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 64;

  // angle constants in Q2.30
  localparam longint HALF_PI_Q30  = 64'd1686629713;
  localparam longint SIXTH_PI_Q30 = 64'd562209904;

  localparam int DEFAULT_SINE_TABLE_DEPTH = 256;
  localparam int DEFAULT_FRAC_BITS        = 16;

  // one quarter-wave sine entry from its Q2.30 angle, 8-term Taylor series
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0] t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    t   = x;
    sum = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (n)
        1: t = t / 64'd6;
        2: t = t / 64'd20;
        3: t = t / 64'd42;
        4: t = t / 64'd72;
        5: t = t / 64'd110;
        6: t = t / 64'd156;
        default: t = t / 64'd210;
      endcase
      if (n % 2 == 1) sum = sum - signed'(t);
      else sum = sum + signed'(t);
    end
    r = (sum + 64'sd8192) >>> 14;
    if (r < 0) r = 0;
    if (r > 64'sd65535) r = 64'sd65535;
    return r[15:0];
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
    if (v > 60'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -60'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/planned_trajectory_tracking_step_unit.sv =====
// Planned trajectory tracking step unit: one shared multiplier under a step sequencer.
// A load item (tuser = 0) copies the measured state into the planned state as it is
// accepted and gives no result beat. A step item (tuser = 1) keeps the input not ready
// from the acceptance of its beat until its last product is retired. A step makes 26
// multiplications, one per cycle unless the output stalls, on a single 18 x 40 bit
// signed multiplier with a registered product (12 for the three yaw rotations, 4 for
// the gain terms, 2 for the command scaling and 8 for the planned state update), and
// then retires the last product. The command beat turns valid when the second command
// scaling product is retired. The input is not ready while a step runs; the command
// beat waits in an output register, and a step holds before writing it only if the
// previous beat has not been taken. The user must write the configuration over the
// APB port only while the unit is idle; the unit itself does not enforce it.
module planned_trajectory_tracking_step_unit #(
  parameter int SINE_TABLE_DEPTH = ptt_pkg::DEFAULT_SINE_TABLE_DEPTH,
  parameter int FRAC_BITS        = ptt_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // plan_u_x, plan_u_y, meas_vel_x, meas_vel_y, meas_pos_x, meas_pos_y, yaw, zero pad
  input  logic [ptt_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,   // op
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ptt_pkg::OUT_DATA_W-1:0] m_tdata,   // cmd_body_x, cmd_body_y
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ptt_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH) + 1;
  localparam longint BANK_LIMIT =
    (SIXTH_PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [39:0] BANK_POS = 40'(BANK_LIMIT);
  localparam logic signed [39:0] BANK_NEG = -40'(BANK_LIMIT);
  localparam logic signed [59:0] RND_F    = 60'sd1 <<< (FRAC_BITS - 1);

  // sequencer step codes
  localparam logic [4:0] ST_ROT_END = 5'd11;
  localparam logic [4:0] ST_CMD_X0  = 5'd12;
  localparam logic [4:0] ST_CMD_X1  = 5'd13;
  localparam logic [4:0] ST_CMD_Y0  = 5'd14;
  localparam logic [4:0] ST_CMD_Y1  = 5'd15;
  localparam logic [4:0] ST_OUT_X   = 5'd16;
  localparam logic [4:0] ST_OUT_Y   = 5'd17;
  localparam logic [4:0] ST_PVX     = 5'd18;
  localparam logic [4:0] ST_PVX_U   = 5'd19;
  localparam logic [4:0] ST_PPX     = 5'd20;
  localparam logic [4:0] ST_PPX_U   = 5'd21;
  localparam logic [4:0] ST_PVY     = 5'd22;
  localparam logic [4:0] ST_PVY_U   = 5'd23;
  localparam logic [4:0] ST_PPY     = 5'd24;
  localparam logic [4:0] ST_LAST    = 5'd25;

  // quarter-wave sine table, constant
  logic [15:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XK = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    localparam logic [15:0] SK = sine_entry(XK);
    assign sine_rom[k] = SK;
  end

  // configuration registers
  logic [CFG_W-1:0] cfg [NUM_CFG];
  logic [2:0] cfg_idx;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_VEL_DECAY]    <= RST_VEL_DECAY;
      cfg[REG_VEL_TO_POS]   <= RST_VEL_TO_POS;
      cfg[REG_INPUT_TO_VEL] <= RST_INPUT_TO_VEL;
      cfg[REG_INPUT_TO_POS] <= RST_INPUT_TO_POS;
      cfg[REG_VEL_GAIN]     <= RST_VEL_GAIN;
      cfg[REG_POS_GAIN]     <= RST_POS_GAIN;
      cfg[REG_CMD_SCALE]    <= RST_CMD_SCALE;
    end else if (psel && penable && pwrite && pready && (32'(cfg_idx) < NUM_CFG)) begin
      cfg[cfg_idx] <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < NUM_CFG) prdata = 32'(cfg[cfg_idx]);
  end

  // input field unpacking
  logic signed [16:0] in_ux, in_uy;
  logic signed [31:0] in_mvx, in_mvy, in_mpx, in_mpy;
  logic [15:0]        in_yaw;
  assign in_ux  = s_tdata[16:0];
  assign in_uy  = s_tdata[33:17];
  assign in_mvx = s_tdata[65:34];
  assign in_mvy = s_tdata[97:66];
  assign in_mpx = s_tdata[129:98];
  assign in_mpy = s_tdata[161:130];
  assign in_yaw = s_tdata[177:162];

  // sine (index 0) and cosine (index 1) lookups
  logic signed [17:0] trig [2];
  for (genvar g = 0; g < 2; g++) begin : g_trig
    logic [15:0]      ph;
    logic [31:0]      kprod;
    logic [IDX_W-1:0] kk, idx;
    logic [16:0]      mag;
    always_comb begin
      ph    = in_yaw + 16'(g * 16384);
      kprod = 32'(ph[13:0]) * 32'(SINE_TABLE_DEPTH);
      kk    = IDX_W'(kprod >> 14);
      idx   = ph[14] ? IDX_W'(SINE_TABLE_DEPTH) - kk : kk;
      if (32'(idx) >= SINE_TABLE_DEPTH) mag = 17'd65536;
      else mag = 17'(sine_rom[idx[IDX_W-2:0]]);
      trig[g] = ph[15] ? -18'(signed'({1'b0, mag})) : 18'(signed'({1'b0, mag}));
    end
  end

  // bank input clamp
  logic signed [16:0] cl_ux, cl_uy;
  always_comb begin
    cl_ux = in_ux;
    if (40'(in_ux) > BANK_POS) cl_ux = 17'(BANK_POS);
    if (40'(in_ux) < BANK_NEG) cl_ux = 17'(BANK_NEG);
    cl_uy = in_uy;
    if (40'(in_uy) > BANK_POS) cl_uy = 17'(BANK_POS);
    if (40'(in_uy) < BANK_NEG) cl_uy = 17'(BANK_NEG);
  end

  // state and working registers
  logic signed [31:0] pvx, pvy, ppx, ppy;
  logic signed [31:0] mvx, mvy, mpx, mpy, tmp;
  logic signed [16:0] ux, uy;
  logic signed [17:0] sn, cs;
  logic signed [34:0] fx, fy, mx, my, ex, ey;
  logic signed [39:0] cx, cy;
  logic signed [59:0] acc;
  logic signed [57:0] prod;
  logic [4:0]         cnt, act;
  logic               busy, act_vld;

  logic s_acc, stall, adv;
  assign s_tready = !busy;
  assign s_acc    = s_tvalid && s_tready;
  assign stall    = act_vld && (act == ST_OUT_X) && m_tvalid && !m_tready;
  assign adv      = busy && !stall;

  // operand select for the shared multiplier
  logic signed [17:0] mul_a;
  logic signed [39:0] mul_b;
  logic signed [39:0] rx, ry;
  always_comb begin
    case (cnt[3:2])
      2'd0:    begin rx = 40'(pvx); ry = 40'(pvy); end
      2'd1:    begin rx = 40'(mvx); ry = 40'(mvy); end
      default: begin rx = 40'(ppx) - 40'(mpx); ry = 40'(ppy) - 40'(mpy); end
    endcase
    mul_a = cs;
    mul_b = rx;
    if (cnt <= ST_ROT_END) begin
      case (cnt[1:0])
        2'd0:    begin mul_a = cs; mul_b = rx; end
        2'd1:    begin mul_a = sn; mul_b = ry; end
        2'd2:    begin mul_a = sn; mul_b = rx; end
        default: begin mul_a = cs; mul_b = ry; end
      endcase
    end else begin
      case (cnt)
        ST_CMD_X0: begin mul_a = 18'(cfg[REG_VEL_GAIN]); mul_b = 40'(fx) - 40'(mx); end
        ST_CMD_X1: begin mul_a = 18'(cfg[REG_POS_GAIN]); mul_b = 40'(ex); end
        ST_CMD_Y0: begin mul_a = 18'(cfg[REG_VEL_GAIN]); mul_b = 40'(fy) - 40'(my); end
        ST_CMD_Y1: begin mul_a = 18'(cfg[REG_POS_GAIN]); mul_b = 40'(ey); end
        ST_OUT_X:  begin mul_a = 18'(cfg[REG_CMD_SCALE]); mul_b = cx; end
        ST_OUT_Y:  begin mul_a = 18'(cfg[REG_CMD_SCALE]); mul_b = cy; end
        ST_PVX:    begin mul_a = 18'(cfg[REG_VEL_DECAY]); mul_b = 40'(pvx); end
        ST_PVX_U:  begin mul_a = 18'(cfg[REG_INPUT_TO_VEL]); mul_b = 40'(ux); end
        ST_PPX:    begin mul_a = 18'(cfg[REG_VEL_TO_POS]); mul_b = 40'(pvx); end
        ST_PPX_U:  begin mul_a = 18'(cfg[REG_INPUT_TO_POS]); mul_b = 40'(ux); end
        ST_PVY:    begin mul_a = 18'(cfg[REG_VEL_DECAY]); mul_b = 40'(pvy); end
        ST_PVY_U:  begin mul_a = 18'(cfg[REG_INPUT_TO_VEL]); mul_b = 40'(uy); end
        ST_PPY:    begin mul_a = 18'(cfg[REG_VEL_TO_POS]); mul_b = 40'(pvy); end
        ST_LAST:   begin mul_a = 18'(cfg[REG_INPUT_TO_POS]); mul_b = 40'(uy); end
        default:   begin mul_a = cs; mul_b = rx; end
      endcase
    end
  end

  // rounded views of the registered product
  logic signed [59:0] p_ext, r16, rnd_f, rot_sum;
  assign p_ext   = 60'(prod);
  assign rnd_f   = (p_ext + RND_F) >>> FRAC_BITS;
  assign rot_sum = act[0] ? ((act[1]) ? acc + p_ext : acc - p_ext) : p_ext;
  assign r16     = (rot_sum + 60'sd32768) >>> 16;

  // sequencer, product register and datapath actions
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      act_vld  <= 1'b0;
      cnt      <= '0;
      act      <= '0;
      m_tvalid <= 1'b0;
      pvx <= '0; pvy <= '0; ppx <= '0; ppy <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      if (s_acc) begin
        if (s_tuser == OP_LOAD) begin
          pvx <= in_mvx; pvy <= in_mvy; ppx <= in_mpx; ppy <= in_mpy;
        end else begin
          busy    <= 1'b1;
          cnt     <= '0;
          act_vld <= 1'b0;
          mvx <= in_mvx; mvy <= in_mvy; mpx <= in_mpx; mpy <= in_mpy;
          ux  <= cl_ux;  uy  <= cl_uy;
          sn  <= trig[0]; cs <= trig[1];
        end
      end

      if (adv) begin
        prod    <= mul_a * mul_b;
        act     <= cnt;
        act_vld <= (cnt <= ST_LAST);
        cnt     <= cnt + 5'd1;
        if (act_vld) begin
          if (act <= ST_ROT_END) begin
            // rotation: even steps open the sum, odd steps close and round it
            if (!act[0]) acc <= p_ext;
            else begin
              case ({act[3:2], act[1]})
                3'b000:  fx <= 35'(r16);
                3'b001:  fy <= 35'(r16);
                3'b010:  mx <= 35'(r16);
                3'b011:  my <= 35'(r16);
                3'b100:  ex <= 35'(r16);
                default: ey <= 35'(r16);
              endcase
            end
          end else begin
            case (act)
              ST_CMD_X0: acc <= 60'(fx) + rnd_f;
              ST_CMD_X1: cx  <= 40'(acc + rnd_f);
              ST_CMD_Y0: acc <= 60'(fy) + rnd_f;
              ST_CMD_Y1: cy  <= 40'(acc + rnd_f);
              ST_OUT_X:  m_tdata[31:0] <= sat32(rnd_f);
              ST_OUT_Y: begin
                m_tdata[63:32] <= sat32(rnd_f);
                m_tvalid       <= 1'b1;
              end
              ST_PVX:    acc <= rnd_f;
              ST_PVX_U:  tmp <= sat32(acc - rnd_f);
              ST_PPX:    acc <= 60'(ppx) + rnd_f;
              ST_PPX_U: begin
                ppx <= sat32(acc - rnd_f);
                pvx <= tmp;
              end
              ST_PVY:    acc <= rnd_f;
              ST_PVY_U:  tmp <= sat32(acc + rnd_f);
              ST_PPY:    acc <= 60'(ppy) + rnd_f;
              ST_LAST: begin
                // the step count has passed the last step, so act_vld drops here too
                ppy     <= sat32(acc + rnd_f);
                pvy     <= tmp;
                busy    <= 1'b0;
              end
              default: acc <= acc;
            endcase
          end
        end
      end
    end
  end

  // checks
  `include "planned_trajectory_tracking_step_unit_assert.svh"

  `PTT_ASSERT(a_step_starts, (s_acc && s_tuser == OP_STEP) |=> (busy && cnt == 5'd0), "step did not start")
  `PTT_ASSERT(a_load_copies, (s_acc && s_tuser == OP_LOAD) |=> (pvx == $past(in_mvx) && !busy), "load lost")
  `PTT_ASSERT(a_beat_in_step, $rose(m_tvalid) |-> busy, "result beat outside a step")
  `PTT_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !m_tvalid), "not idle after reset")

endmodule

// ===== sim/tb.sv =====
// Testbench of the planned trajectory tracking step unit: stream stimulus, APB setup, scoreboard
module tb;
  import ptt_pkg::*;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } cmd_t;

  // bank limit at Q16.16: round(pi/6 * 2^16)
  localparam longint BANK_LIM = (SIXTH_PI_Q30 + (64'sd1 <<< 13)) >>> 14;

  // scoreboard: own copy of planned state, coefficients and sine table
  class track_sb;
    longint coef[NUM_CFG];
    longint pvx, ppx, pvy, ppy;
    longint qsin[256];
    cmd_t cmd_q[$];
    int errs;

    function void init();
      longint unsigned x, t;
      longint sum, r;
      coef[0] = 60797; coef[1] = 6314; coef[2] = 61938; coef[3] = 3136;
      coef[4] = 16384; coef[5] = 65536; coef[6] = 32768;
      pvx = 0; ppx = 0; pvy = 0; ppy = 0; errs = 0;
      for (int k = 0; k < 256; k++) begin
        x = (longint'(k) * HALF_PI_Q30) / 256;
        t = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
          t = (t * x) >> 30;
          t = (t * x) >> 30;
          t = t / ((2 * n) * (2 * n + 1));
          if (n % 2) sum -= t; else sum += t;
        end
        r = (sum + 8192) >>> 14;
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        qsin[k] = r;
      end
    endfunction

    function longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint scale(longint c, longint v);
      return rnd(c * v, 16);
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint sin_q16(int unsigned p);
      int unsigned q, k, j;
      longint v;
      q = (p >> 14) & 3;
      k = ((p & 16'h3fff) * 256) >> 14;
      j = (q & 1) ? 256 - k : k;
      v = (j >= 256) ? 65536 : qsin[j];
      return (q & 2) ? -v : v;
    endfunction

    function void note_item(logic op, logic signed [16:0] ux17, logic signed [16:0] uy17,
                            logic signed [31:0] mvx, logic signed [31:0] mvy,
                            logic signed [31:0] mpx, logic signed [31:0] mpy,
                            logic [15:0] yaw);
      longint s, c, fx, fy, mx, my, ex, ey, cx, cy, ux, uy, dx, dy;
      cmd_t e;
      if (op == OP_LOAD) begin
        pvx = mvx; pvy = mvy; ppx = mpx; ppy = mpy;
        return;
      end
      s = sin_q16(yaw);
      c = sin_q16((yaw + 16384) & 16'hffff);
      fx = rnd(c * pvx - s * pvy, 16);
      fy = rnd(s * pvx + c * pvy, 16);
      mx = rnd(c * mvx - s * mvy, 16);
      my = rnd(s * mvx + c * mvy, 16);
      dx = ppx - mpx;
      dy = ppy - mpy;
      ex = rnd(c * dx - s * dy, 16);
      ey = rnd(s * dx + c * dy, 16);
      cx = fx + scale(coef[4], fx - mx) + scale(coef[5], ex);
      cy = fy + scale(coef[4], fy - my) + scale(coef[5], ey);
      e.cx = sat(scale(coef[6], cx));
      e.cy = sat(scale(coef[6], cy));
      cmd_q.push_back(e);
      ux = ux17; uy = uy17;
      if (ux > BANK_LIM) ux = BANK_LIM;
      if (ux < -BANK_LIM) ux = -BANK_LIM;
      if (uy > BANK_LIM) uy = BANK_LIM;
      if (uy < -BANK_LIM) uy = -BANK_LIM;
      dx = sat(scale(coef[0], pvx) - scale(coef[2], ux));
      dy = sat(scale(coef[0], pvy) + scale(coef[2], uy));
      ppx = sat(scale(coef[1], pvx) + ppx - scale(coef[3], ux));
      ppy = sat(scale(coef[1], pvy) + ppy + scale(coef[3], uy));
      pvx = dx; pvy = dy;
    endfunction

    function void check_cmd(logic [63:0] d);
      cmd_t e;
      if (cmd_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = cmd_q.pop_front();
      if (d[31:0] !== e.cx || d[63:32] !== e.cy) begin
        errs++;
        if (errs <= 10)
          $display("cmd mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                   e.cx, e.cy, $signed(d[31:0]), $signed(d[63:32]));
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  planned_trajectory_tracking_step_unit dut (.*);

  track_sb sb;
  int src_idle_pct, snk_stall_pct;
  int hold_off;
  int quiet;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random stall, optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_cmd(m_tdata);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted beat or APB select
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [16:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.coef[idx] = val;
  endtask

  // valid stays high after an accepted beat unless the sender idles first
  task automatic send_item(input logic op, input logic [16:0] ux, input logic [16:0] uy,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] yaw);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {8'd0, yaw, py, px, vy, vx, uy, ux};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, ux, uy, vx, vy, px, py, yaw);
  endtask

  function automatic logic [16:0] rand_u();
    case ($urandom_range(3))
      0: return 17'($urandom_range(34316 * 2) - 34316);
      1: return 17'($urandom);
      2: return $urandom_range(1) ? 17'd34316 : -17'sd34316;
      default: return 17'($urandom_range(4000) - 2000);
    endcase
  endfunction

  function automatic logic [31:0] rand_v();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_item(input int load_pct);
    send_item(($urandom_range(99) < load_pct) ? OP_LOAD : OP_STEP, rand_u(), rand_u(),
              rand_v(), rand_v(), rand_v(), rand_v(), 16'($urandom));
  endtask

  task automatic drain();
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sb.init();
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    src_idle_pct = 0; snk_stall_pct = 0; hold_off = 0; quiet = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: step before load, field extremes, clamp edges, quadrant yaws
    send_item(OP_STEP, 17'h10000, 17'h0ffff, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
    send_item(OP_LOAD, 17'd0, 17'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 16'hffff);
    send_item(OP_STEP, 17'd34316, -17'sd34316, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 16'd16384);
    send_item(OP_STEP, 17'd34317, -17'sd34317, 32'hffffffff, 32'd0, 32'd1, 32'd0, 16'd32768);
    send_item(OP_STEP, 17'h0ffff, 17'h10000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32'h80000000, 16'd49152);
    for (int k = 0; k < 12; k++)
      send_item(OP_STEP, rand_u(), rand_u(), rand_v(), rand_v(), rand_v(), rand_v(),
                16'(k * 5461 + k));
    send_item(OP_LOAD, 17'd0, 17'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 16'd0);
    send_item(OP_STEP, 17'd0, 17'd0, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
              32'haaaaaaaa, 16'haaaa);
    send_item(OP_STEP, 17'h15555, 17'h0aaaa, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
              32'h55555555, 16'h5555);
    s_tvalid <= 0;
    drain();

    // random phases over several coefficient settings and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < NUM_CFG; r++) begin
        case (ph)
          0: reg_write(3'(r), 17'h1ffff);
          1: reg_write(3'(r), 17'd0);
          5: reg_write(3'(r), 17'($urandom_range(65536)));
          default: reg_write(3'(r), 17'($urandom));
        endcase
      end
      case (ph % 4)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 66; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 66; end
        default: begin src_idle_pct = 11; snk_stall_pct = 11; end
      endcase
      if (ph == 4) hold_off = 400;
      for (int i = 0; i < 100; i++) random_item(15);
      s_tvalid <= 0;
      drain();
    end

    if (sb.errs == 0 && sb.cmd_q.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
